// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the key press classifier
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition in this cycle implies a result in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, cond, consq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (consq)) \
        else $error(msg);

`endif

// ===== hw/rtl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// widths, reset values, codes and types of the key press classifier
// ----------------------------------------------------------------------------
`default_nettype none

package kpc_pkg;

    localparam int DEBOUNCE_W = 10;
    localparam int TICKS_W    = 16;
    localparam int CLICKS_W   = 8;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = 10'd50;
    localparam logic [TICKS_W-1:0]    LONG_RST     = 16'd2000;
    localparam logic [TICKS_W-1:0]    GAP_RST      = 16'd400;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MAX = '1;
    localparam logic [TICKS_W-1:0]    TICKS_MAX    = '1;
    localparam logic [CLICKS_W-1:0]   CLICKS_MAX   = '1;

    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP      = 2'd2;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [TICKS_W-1:0]    long_press_ticks;
        logic [TICKS_W-1:0]    click_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic [EVENT_W-1:0]  press_event;
        logic [TICKS_W-1:0]  press_ticks;
        logic                clicks_done;
        logic [CLICKS_W-1:0] click_total;
        logic                stable_key;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/kpc_intf.sv =====
// ----------------------------------------------------------------------------
// kpc channel interfaces
// key sample, result and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

interface kpc_key_if;
    logic valid;
    logic ready;
    logic raw_level;

    modport source (output valid, output raw_level, input ready);
    modport sink   (input valid, input raw_level, output ready);
endinterface

interface kpc_res_if;
    import kpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [EVENT_W-1:0]  press_event;
    logic [TICKS_W-1:0]  press_ticks;
    logic                clicks_done;
    logic [CLICKS_W-1:0] click_total;
    logic                stable_key;

    modport source (
        output valid, output press_event, output press_ticks,
        output clicks_done, output click_total, output stable_key,
        input  ready
    );
    modport sink (
        input  valid, input press_event, input press_ticks,
        input  clicks_done, input click_total, input stable_key,
        output ready
    );
endinterface

interface kpc_cfg_if;
    import kpc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kpc_cfg.sv =====
// ----------------------------------------------------------------------------
// kpc_cfg
// configuration registers: debounce time, long press and click gap thresholds
// ----------------------------------------------------------------------------
`default_nettype none

module kpc_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  logic [1:0]    i_index,
    input  logic [15:0]   i_data,
    output kpc_pkg::t_cfg o_cfg
);
    import kpc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks   <= DEBOUNCE_RST;
            r_cfg.long_press_ticks <= LONG_RST;
            r_cfg.click_gap_ticks  <= GAP_RST;
        end else if (i_wr) begin
            case (i_index)
                CFG_DEBOUNCE: r_cfg.debounce_ticks   <= i_data[DEBOUNCE_W-1:0];
                CFG_LONG:     r_cfg.long_press_ticks <= i_data[TICKS_W-1:0];
                CFG_GAP:      r_cfg.click_gap_ticks  <= i_data[TICKS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/kpc_step.sv =====
// ----------------------------------------------------------------------------
// kpc_step
// per-tick state update: debounce, press timing and click sequence tracking
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module kpc_step (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_raw,
    input  kpc_pkg::t_cfg    i_cfg,
    output kpc_pkg::t_result o_res
);
    import kpc_pkg::*;

    logic                  r_prev_raw,    n_prev_raw;
    logic                  r_stable,      n_stable;
    logic                  r_db_active,   n_db_active;
    logic [DEBOUNCE_W-1:0] r_db_count,    n_db_count;
    logic [TICKS_W-1:0]    r_press_dur,   n_press_dur;
    logic [CLICKS_W-1:0]   r_click_count, n_click_count;
    logic                  r_ct_active,   n_ct_active;
    logic [TICKS_W-1:0]    r_ct_count,    n_ct_count;
    t_result               res;

    always_comb begin
        n_prev_raw    = i_raw;
        n_stable      = r_stable;
        n_db_active   = r_db_active;
        n_db_count    = r_db_count;
        n_press_dur   = r_press_dur;
        n_click_count = r_click_count;
        n_ct_active   = r_ct_active;
        n_ct_count    = r_ct_count;
        res           = '0;

        // click gap timer
        if (r_ct_active) begin
            if (r_ct_count != TICKS_MAX) begin
                n_ct_count = r_ct_count + 16'd1;
            end
            if (n_ct_count >= i_cfg.click_gap_ticks) begin
                res.clicks_done = 1'b1;
                res.click_total = r_click_count;
                n_click_count   = '0;
                n_ct_active     = 1'b0;
                n_ct_count      = '0;
            end
        end

        if (r_stable && r_press_dur != TICKS_MAX) begin
            n_press_dur = r_press_dur + 16'd1;
        end

        // debounce and release classification
        if (r_db_active) begin
            if (r_db_count != DEBOUNCE_MAX) begin
                n_db_count = r_db_count + 10'd1;
            end
            if (n_db_count >= i_cfg.debounce_ticks) begin
                n_db_active = 1'b0;
                n_db_count  = '0;
                if (i_raw != r_stable) begin
                    n_stable = i_raw;
                    if (i_raw) begin
                        n_press_dur = '0;
                    end else if (n_press_dur >= i_cfg.long_press_ticks) begin
                        res.press_event = EV_LONG;
                        res.press_ticks = n_press_dur;
                        n_click_count   = '0;
                        n_ct_active     = 1'b0;
                        n_ct_count      = '0;
                    end else if (n_press_dur >= {6'd0, i_cfg.debounce_ticks}) begin
                        res.press_event = EV_SHORT;
                        res.press_ticks = n_press_dur;
                        if (n_click_count != CLICKS_MAX) begin
                            n_click_count = n_click_count + 8'd1;
                        end
                        n_ct_active = 1'b1;
                        n_ct_count  = '0;
                    end
                end
            end
        end else if (i_raw != r_prev_raw) begin
            n_db_active = 1'b1;
            n_db_count  = '0;
        end

        res.stable_key = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw    <= 1'b0;
            r_stable      <= 1'b0;
            r_db_active   <= 1'b0;
            r_db_count    <= '0;
            r_press_dur   <= '0;
            r_click_count <= '0;
            r_ct_active   <= 1'b0;
            r_ct_count    <= '0;
        end else if (i_step) begin
            r_prev_raw    <= n_prev_raw;
            r_stable      <= n_stable;
            r_db_active   <= n_db_active;
            r_db_count    <= n_db_count;
            r_press_dur   <= n_press_dur;
            r_click_count <= n_click_count;
            r_ct_active   <= n_ct_active;
            r_ct_count    <= n_ct_count;
        end
    end

    assign o_res = res;

    `ASSERT_NEXT(a_long_clears_clicks, i_clk, i_rst_n, i_step && res.press_event == EV_LONG, r_click_count == 8'd0 && !r_ct_active, "long press left click sequence running")
    `ASSERT_NEXT(a_short_arms_timer, i_clk, i_rst_n, i_step && res.press_event == EV_SHORT, r_ct_active && r_ct_count == 16'd0 && r_click_count != 8'd0, "short press did not start click timer")
    `ASSERT_NEXT(a_event_on_release, i_clk, i_rst_n, i_step && res.press_event != EV_NONE, !r_stable, "press event without stable release")
    `ASSERT_NEXT(a_idle_holds_state, i_clk, i_rst_n, !i_step, $stable(r_stable) && $stable(r_click_count) && $stable(r_press_dur), "state moved without a tick")

endmodule

`default_nettype wire

// ===== hw/rtl/key_press_classifier.sv =====
// ----------------------------------------------------------------------------
// key_press_classifier
// debounced key with short press, long press and multi-click detection
// ----------------------------------------------------------------------------
// usage:
//   i_key carries one raw key sample per millisecond tick (raw_level).
//   o_res returns exactly one result per sample: press event and duration,
//   click sequence end with its click count, and the debounced key level.
//   i_cfg writes debounce_ticks (index 0), long_press_ticks (index 1) and
//   click_gap_ticks (index 2); it is always ready, other indexes are ignored.
//   configuration must be written only while no request is in flight (unchecked).
// timing:
//   a request is held in the input register until the output register is free,
//   then its result is loaded into the output register, which drives o_res.valid.
//   one request per cycle is sustained while o_res is not stalled; the per-tick
//   update is combinational counter and compare logic.
// reset and stall:
//   synchronous reset clears all key state and loads the default thresholds.
//   while o_res is stalled the input register still takes one more request,
//   after that i_key.ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_press_classifier (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kpc_key_if.sink   i_key,
    kpc_cfg_if.sink   i_cfg,
    kpc_res_if.source o_res
);
    import kpc_pkg::*;

    logic    r_in_valid;
    logic    r_in_raw;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;
    t_cfg    cfg;
    t_result step_res;

    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_key.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    kpc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    kpc_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_raw   (r_in_raw),
        .i_cfg   (cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_key.valid && i_key.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_in_raw <= i_key.raw_level;
        end
        if (advance) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.press_event = r_out.press_event;
    assign o_res.press_ticks = r_out.press_ticks;
    assign o_res.clicks_done = r_out.clicks_done;
    assign o_res.click_total = r_out.click_total;
    assign o_res.stable_key  = r_out.stable_key;

endmodule

`default_nettype wire
